// File: hdl/sfa_pkg.sv
// Shared types and constants for the sprite frame animator.
package sfa_pkg;

    localparam int FRAME_W   = 10;
    localparam int TIME_W    = 32;
    localparam int SIZE_W    = 12;
    localparam int RECT_W    = 22;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int DIV_STEPS = FRAME_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [FRAME_W-1:0] RST_START_FRAME   = '0;
    localparam logic [FRAME_W-1:0] RST_END_FRAME     = '0;
    localparam logic [TIME_W-1:0]  RST_FRAME_DELAY   = 32'd65536;
    localparam logic               RST_LOOP_MODE     = 1'b1;
    localparam logic [FRAME_W-1:0] RST_SHEET_COLUMNS = 10'd1;
    localparam logic [SIZE_W-1:0]  RST_FRAME_WIDTH   = 12'd2;
    localparam logic [SIZE_W-1:0]  RST_FRAME_HEIGHT  = 12'd2;

    typedef enum logic [0:0] {
        CMD_TICK      = 1'b0,
        CMD_SET_FRAME = 1'b1
    } t_command;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_FRAME   = 3'd0,
        CFG_END_FRAME     = 3'd1,
        CFG_FRAME_DELAY   = 3'd2,
        CFG_LOOP_MODE     = 3'd3,
        CFG_SHEET_COLUMNS = 3'd4,
        CFG_FRAME_WIDTH   = 3'd5,
        CFG_FRAME_HEIGHT  = 3'd6
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_STEP,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_MUL_X,
        ST_MUL_Y,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [0:0]          command;
        logic [TIME_W-1:0]   elapsed_time;
        logic [FRAME_W-1:0]  frame_number;
    } t_in_item;

    typedef struct packed {
        logic [FRAME_W-1:0]  current_frame;
        logic [RECT_W-1:0]   rect_left;
        logic [RECT_W-1:0]   rect_top;
        logic [RECT_W-1:0]   rect_right;
        logic [RECT_W-1:0]   rect_bottom;
        logic                completed;
    } t_out_item;

    typedef struct packed {
        logic                start;
        logic [FRAME_W-1:0]  dividend;
        logic [FRAME_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [FRAME_W-1:0]  quotient;
        logic [FRAME_W-1:0]  remainder;
    } t_div_status;

endpackage

// File: hdl/sfa_if.sv
// Valid/ready channel interfaces for animator requests and results.
interface sfa_in_if;
    logic               valid;
    logic               ready;
    sfa_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sfa_out_if;
    logic                valid;
    logic                ready;
    sfa_pkg::t_out_item  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hdl/sfa_divider.sv
// Restoring divider that yields one quotient bit per cycle.
module sfa_divider (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sfa_pkg::t_div_req     i_req,
    output sfa_pkg::t_div_status  o_status
);

    logic [sfa_pkg::DIV_CNT_W-1:0] r_count;
    logic                          r_done;
    logic [sfa_pkg::FRAME_W-1:0]   r_rem;
    logic [sfa_pkg::FRAME_W-1:0]   r_quo;
    logic [sfa_pkg::FRAME_W-1:0]   r_divisor;
    logic [sfa_pkg::FRAME_W:0]     w_shifted;
    logic [sfa_pkg::FRAME_W:0]     w_trial;

    assign w_shifted = {r_rem, r_quo[sfa_pkg::FRAME_W-1]};
    assign w_trial   = w_shifted - {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else if (i_req.start) begin
            r_count <= sfa_pkg::DIV_CNT_W'(sfa_pkg::DIV_STEPS);
            r_done  <= 1'b0;
        end else if (r_count != '0) begin
            r_count <= r_count - 1'b1;
            r_done  <= (r_count == sfa_pkg::DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem     <= '0;
            r_quo     <= i_req.dividend;
            r_divisor <= i_req.divisor;
        end else if (r_count != '0) begin
            if (!w_trial[sfa_pkg::FRAME_W]) begin
                r_rem <= w_trial[sfa_pkg::FRAME_W-1:0];
                r_quo <= {r_quo[sfa_pkg::FRAME_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shifted[sfa_pkg::FRAME_W-1:0];
                r_quo <= {r_quo[sfa_pkg::FRAME_W-2:0], 1'b0};
            end
        end
    end

    assign o_status.done      = r_done;
    assign o_status.quotient  = r_quo;
    assign o_status.remainder = r_rem;

endmodule

// File: hdl/sprite_frame_animator.sv
// Top level of the sprite-sheet frame animation controller.
// Each accepted request passes through the accumulate, step (running ticks only), divide, multiply and done states.
// Throughput: one request at a time; the next is taken the cycle after the result is registered.
// Column and row come from the serial divider as remainder and quotient of the frame number.
// A result waiting in the output register holds the controller in its done state, so it blocks the next request.
// Synchronous active-low reset restores register defaults and clears frame, time and flag.
module sprite_frame_animator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    sfa_in_if.sink                            i_in,
    sfa_out_if.source                         o_out,
    input  logic                              i_cfg_we,
    input  logic [sfa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sfa_pkg::CFG_DAT_W-1:0]     i_cfg_data
);

    logic [sfa_pkg::FRAME_W-1:0] r_start_frame;
    logic [sfa_pkg::FRAME_W-1:0] r_end_frame;
    logic [sfa_pkg::TIME_W-1:0]  r_frame_delay;
    logic                        r_loop_mode;
    logic [sfa_pkg::FRAME_W-1:0] r_sheet_columns;
    logic [sfa_pkg::SIZE_W-1:0]  r_frame_width;
    logic [sfa_pkg::SIZE_W-1:0]  r_frame_height;

    sfa_pkg::t_state             r_state;
    sfa_pkg::t_state             n_state;
    sfa_pkg::t_in_item           r_item;
    logic [sfa_pkg::FRAME_W-1:0] r_frame;
    logic [sfa_pkg::TIME_W-1:0]  r_acc;
    logic                        r_done_flag;
    logic [sfa_pkg::RECT_W-1:0]  r_left;
    logic [sfa_pkg::RECT_W-1:0]  r_top;
    logic                        r_out_valid;
    sfa_pkg::t_out_item          r_out;

    logic                        w_active;
    logic [sfa_pkg::TIME_W:0]    w_sum;
    logic [sfa_pkg::TIME_W-1:0]  w_sat_sum;
    logic [sfa_pkg::TIME_W:0]    w_diff;
    logic                        w_advance;
    logic [sfa_pkg::FRAME_W:0]   w_next;
    logic                        w_out_of_range;
    logic [sfa_pkg::FRAME_W-1:0] w_mul_a;
    logic [sfa_pkg::SIZE_W-1:0]  w_mul_b;
    logic [sfa_pkg::RECT_W-1:0]  w_product;
    logic                        w_out_free;
    sfa_pkg::t_div_req           w_div_req;
    sfa_pkg::t_div_status        w_div_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_frame   <= sfa_pkg::RST_START_FRAME;
            r_end_frame     <= sfa_pkg::RST_END_FRAME;
            r_frame_delay   <= sfa_pkg::RST_FRAME_DELAY;
            r_loop_mode     <= sfa_pkg::RST_LOOP_MODE;
            r_sheet_columns <= sfa_pkg::RST_SHEET_COLUMNS;
            r_frame_width   <= sfa_pkg::RST_FRAME_WIDTH;
            r_frame_height  <= sfa_pkg::RST_FRAME_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (sfa_pkg::t_cfg_index'(i_cfg_index))
                sfa_pkg::CFG_START_FRAME: begin
                    r_start_frame <= i_cfg_data[sfa_pkg::FRAME_W-1:0];
                end
                sfa_pkg::CFG_END_FRAME: begin
                    r_end_frame <= i_cfg_data[sfa_pkg::FRAME_W-1:0];
                end
                sfa_pkg::CFG_FRAME_DELAY: begin
                    r_frame_delay <= i_cfg_data[sfa_pkg::TIME_W-1:0];
                end
                sfa_pkg::CFG_LOOP_MODE: begin
                    r_loop_mode <= i_cfg_data[0];
                end
                sfa_pkg::CFG_SHEET_COLUMNS: begin
                    r_sheet_columns <= i_cfg_data[sfa_pkg::FRAME_W-1:0];
                end
                sfa_pkg::CFG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data[sfa_pkg::SIZE_W-1:0];
                end
                sfa_pkg::CFG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data[sfa_pkg::SIZE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign w_active  = (r_end_frame > r_start_frame);
    assign w_sum     = {1'b0, r_acc} + {1'b0, r_item.elapsed_time};
    assign w_sat_sum = w_sum[sfa_pkg::TIME_W] ? '1 : w_sum[sfa_pkg::TIME_W-1:0];
    assign w_diff    = {1'b0, r_acc} - {1'b0, r_frame_delay};
    assign w_advance = !w_diff[sfa_pkg::TIME_W] && (w_diff[sfa_pkg::TIME_W-1:0] != '0);
    assign w_next    = {1'b0, r_frame} + 1'b1;
    assign w_out_of_range = (w_next < {1'b0, r_start_frame}) || (w_next > {1'b0, r_end_frame});

    assign w_div_req.start    = (r_state == sfa_pkg::ST_DIV_GO);
    assign w_div_req.dividend = r_frame;
    assign w_div_req.divisor  = (r_sheet_columns == '0) ?
                                sfa_pkg::FRAME_W'(1) : r_sheet_columns;

    sfa_divider u_divider (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_div_req),
        .o_status (w_div_status)
    );

    assign w_mul_a   = (r_state == sfa_pkg::ST_MUL_X) ?
                       w_div_status.remainder : w_div_status.quotient;
    assign w_mul_b   = (r_state == sfa_pkg::ST_MUL_X) ? r_frame_width : r_frame_height;
    assign w_product = {{(sfa_pkg::RECT_W-sfa_pkg::FRAME_W){1'b0}}, w_mul_a} *
                       {{(sfa_pkg::RECT_W-sfa_pkg::SIZE_W){1'b0}}, w_mul_b};
    assign w_out_free = !r_out_valid || o_out.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sfa_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = sfa_pkg::ST_ACCUM;
                end
            end
            sfa_pkg::ST_ACCUM: begin
                if (r_item.command == sfa_pkg::CMD_TICK && w_active) begin
                    n_state = sfa_pkg::ST_STEP;
                end else begin
                    n_state = sfa_pkg::ST_DIV_GO;
                end
            end
            sfa_pkg::ST_STEP: begin
                n_state = sfa_pkg::ST_DIV_GO;
            end
            sfa_pkg::ST_DIV_GO: begin
                n_state = sfa_pkg::ST_DIV_WAIT;
            end
            sfa_pkg::ST_DIV_WAIT: begin
                if (w_div_status.done) begin
                    n_state = sfa_pkg::ST_MUL_X;
                end
            end
            sfa_pkg::ST_MUL_X: begin
                n_state = sfa_pkg::ST_MUL_Y;
            end
            sfa_pkg::ST_MUL_Y: begin
                n_state = sfa_pkg::ST_DONE;
            end
            sfa_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = sfa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sfa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfa_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame     <= '0;
            r_acc       <= '0;
            r_done_flag <= 1'b0;
        end else if (r_state == sfa_pkg::ST_ACCUM) begin
            if (r_item.command == sfa_pkg::CMD_TICK) begin
                if (w_active) begin
                    r_acc <= w_sat_sum;
                end
            end else if (r_item.frame_number <= r_end_frame) begin
                r_frame     <= r_item.frame_number;
                r_done_flag <= 1'b0;
            end
        end else if (r_state == sfa_pkg::ST_STEP && w_advance) begin
            r_acc <= w_diff[sfa_pkg::TIME_W-1:0];
            if (!w_out_of_range) begin
                r_frame <= w_next[sfa_pkg::FRAME_W-1:0];
            end else if (r_loop_mode) begin
                r_frame <= r_start_frame;
            end else begin
                r_frame     <= r_end_frame;
                r_done_flag <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == sfa_pkg::ST_IDLE && i_in.valid) begin
            r_item <= i_in.data;
        end
        if (r_state == sfa_pkg::ST_MUL_X) begin
            r_left <= w_product;
        end
        if (r_state == sfa_pkg::ST_MUL_Y) begin
            r_top <= w_product;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == sfa_pkg::ST_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == sfa_pkg::ST_DONE && w_out_free) begin
            r_out.current_frame <= r_frame;
            r_out.rect_left     <= r_left;
            r_out.rect_top      <= r_top;
            r_out.rect_right    <= r_left + sfa_pkg::RECT_W'(r_frame_width);
            r_out.rect_bottom   <= r_top + sfa_pkg::RECT_W'(r_frame_height);
            r_out.completed     <= r_done_flag;
        end
    end

    assign i_in.ready  = (r_state == sfa_pkg::ST_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule
